/* hw/rtl/mbps_pkg.sv */
// Shared types and constants for the masked byte pattern scanner.
// No dependencies; the cell, tracker, top level and testbench import this package.
`default_nettype none

package mbps_pkg;

    // Sizes of the cell chain and the offset counter
    localparam int MAX_PATTERN = 32;
    localparam int OFFSET_BITS = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    // Fixed by the register map
    localparam int PAT_BYTES   = 32;
    localparam int PAT_IDX_W   = $clog2(PAT_BYTES);
    localparam int CFG_LEN_W   = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int PAT_WORDS   = 4;
    localparam int OUT_OFF_W   = 32;

    typedef logic [7:0] t_byte;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LENGTH   = 3'd0,
        REG_CARE     = 3'd1,
        REG_PAT_LOW  = 3'd2,
        REG_PAT_SEC  = 3'd3,
        REG_PAT_THD  = 3'd4,
        REG_PAT_HIGH = 3'd5
    } t_cfg_reg;

    // What one cell compares against
    typedef struct packed {
        logic  care;
        t_byte want;
    } t_cell_cfg;

    // One accepted word as seen by the result tracker
    typedef struct packed {
        logic accept;
        logic last;
        logic all_ok;
    } t_step;

endpackage

`default_nettype wire

/* hw/rtl/mbps_in_if.sv */
// Input channel: one region byte per word with an end-of-region flag.
// Depends on nothing.
`default_nettype none

interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mbps_out_if.sv */
// Result channel: found flag and offset of the first match.
// Depends on nothing.
`default_nettype none

interface mbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mbps_cell.sv */
// One window cell: holds a byte, passes it on, checks the incoming byte.
// Depends on mbps_pkg.
`default_nettype none

module mbps_cell
    import mbps_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_shift,
    input  wire t_byte     i_byte,
    input  wire t_cell_cfg i_cfg,
    output t_byte          o_byte,
    output logic           o_ok
);

    t_byte r_byte;

    // Take the neighbor's byte on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // The byte arriving now is this cell's value after the shift
    assign o_ok   = !i_cfg.care || (i_byte == i_cfg.want);
    assign o_byte = r_byte;

endmodule

`default_nettype wire

/* hw/rtl/mbps_tracker.sv */
// Region bookkeeping: byte count, first match offset and result register.
// Depends on mbps_pkg and mbps_out_if.
`default_nettype none

module mbps_tracker
    import mbps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_step            i_step,
    input  wire logic [LEN_W-1:0] i_len,
    output logic                  o_in_ready,
    mbps_out_if.source            o_result
);

    logic [OFFSET_BITS-1:0] r_seen;
    logic                   r_match;
    logic [OFFSET_BITS-1:0] r_first;
    logic                   r_out_valid;
    logic                   r_out_found;
    logic [OUT_OFF_W-1:0]   r_out_offset;

    logic [OFFSET_BITS-1:0] n_seen;
    logic                   hit_now;
    logic                   match_any;
    logic [OFFSET_BITS-1:0] offset_now;
    logic [63:0]            offset_wide;

    // Saturating count including the current byte
    always_comb begin
        n_seen     = (r_seen == '1) ? r_seen : r_seen + 1'b1;
        hit_now    = !r_match && (n_seen >= OFFSET_BITS'(i_len)) && i_step.all_ok;
        match_any  = r_match || hit_now;
        offset_now = r_match ? r_first : n_seen - OFFSET_BITS'(i_len);
        offset_wide = 64'(offset_now);
    end

    // Region state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_match <= 1'b0;
            r_first <= '0;
        end else if (i_step.accept) begin
            if (i_step.last) begin
                r_seen  <= '0;
                r_match <= 1'b0;
                r_first <= '0;
            end else begin
                r_seen  <= n_seen;
                r_match <= match_any;
                r_first <= match_any ? offset_now : '0;
            end
        end
    end

    // Output register; load on the last byte, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_step.accept && i_step.last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.accept && i_step.last) begin
            r_out_found  <= match_any;
            r_out_offset <= match_any ? offset_wide[OUT_OFF_W-1:0] : '0;
        end
    end

    assign o_in_ready            = !r_out_valid || o_result.ready;
    assign o_result.valid        = r_out_valid;
    assign o_result.found        = r_out_found;
    assign o_result.match_offset = r_out_offset;

endmodule

`default_nettype wire

/* hw/rtl/masked_byte_pattern_scan.sv */
// Top level of the masked byte pattern scanner: registers, cell chain, tracker.
// Depends on mbps_pkg, mbps_in_if, mbps_out_if, mbps_cell and mbps_tracker.
//
//  channel   dir  handshake            payload
//  i_byte    in   valid / ready        data_byte[7:0], last_byte
//  o_result  out  valid / ready        found, match_offset[31:0]
//  config    in   i_cfg_we (no wait)   i_cfg_idx[2:0], i_cfg_data[63:0]
//
// One byte is taken per cycle; all window cells compare in the same cycle the
// byte enters, so the result is registered at the edge that takes the last byte
// and is shown on the next cycle. The result register sets the rate: input stalls
// only while a result waits and o_result.ready is low. Reset is synchronous,
// active low, and resets the window, counters, config and result valid at once.
`default_nettype none

module masked_byte_pattern_scan
    import mbps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    mbps_in_if.sink                    i_byte,
    mbps_out_if.source                 o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_LEN_W-1:0]  r_len;
    logic [PAT_BYTES-1:0]  r_care;
    logic [CFG_DATA_W-1:0] r_pat [PAT_WORDS];

    logic [LEN_W-1:0]      eff_len;
    t_cell_cfg             cell_cfg [MAX_PATTERN];
    t_byte                 chain    [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] cell_ok;
    logic                  accept;
    logic                  in_ready;
    t_step                 step;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= CFG_LEN_W'(1);
            r_care <= '0;
            for (int w = 0; w < PAT_WORDS; w++) begin
                r_pat[w] <= '0;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_LENGTH:   r_len    <= i_cfg_data[CFG_LEN_W-1:0];
                REG_CARE:     r_care   <= i_cfg_data[PAT_BYTES-1:0];
                REG_PAT_LOW:  r_pat[0] <= i_cfg_data;
                REG_PAT_SEC:  r_pat[1] <= i_cfg_data;
                REG_PAT_THD:  r_pat[2] <= i_cfg_data;
                REG_PAT_HIGH: r_pat[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the length: zero acts as one, large values as the chain length
    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (int'(r_len) > MAX_PATTERN) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = LEN_W'(r_len);
        end
    end

    // Cell k sees pattern byte (length - 1 - k); cells past the length pass all
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            logic [LEN_W-1:0]     p;
            logic [PAT_IDX_W-1:0] pi;
            p  = eff_len - LEN_W'(1) - LEN_W'(k);
            pi = PAT_IDX_W'(p);
            cell_cfg[k].care = (k < int'(eff_len)) && (int'(p) < PAT_BYTES) && r_care[pi];
            cell_cfg[k].want = r_pat[pi[PAT_IDX_W-1:3]][pi[2:0]*8 +: 8];
        end
    end

    assign accept       = i_byte.valid && in_ready;
    assign i_byte.ready = in_ready;
    assign chain[0]     = i_byte.data_byte;

    // Window as a row of cells, newest byte at cell 0
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        mbps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (accept),
            .i_byte  (chain[k]),
            .i_cfg   (cell_cfg[k]),
            .o_byte  (chain[k+1]),
            .o_ok    (cell_ok[k])
        );
    end

    assign step.accept = accept;
    assign step.last   = i_byte.last_byte;
    assign step.all_ok = &cell_ok;

    mbps_tracker u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_len      (eff_len),
        .o_in_ready (in_ready),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for masked_byte_pattern_scan: directed and random regions,
// an in-bench window scanner that predicts every report, and random stalls on both sides.
// Depends on mbps_pkg, mbps_in_if, mbps_out_if and the scanner RTL.

module tb;
    import mbps_pkg::*;

    localparam int STUCK_LIMIT   = 3000;
    localparam int RANDOM_TARGET = 220;

    typedef struct packed {
        logic                 found;
        logic [OUT_OFF_W-1:0] offset;
    } t_scan_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mbps_in_if  byte_if ();
    mbps_out_if res_if ();

    masked_byte_pattern_scan dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (byte_if),
        .o_result   (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Register copies as the scanner should hold them
    logic [CFG_LEN_W-1:0]  cfg_length;
    logic [31:0]           cfg_care;
    logic [CFG_DATA_W-1:0] cfg_pattern [PAT_WORDS];

    // Scanner state: newest byte at index 0
    t_byte                  scan_window [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] bytes_in_region;
    logic                   region_hit;
    logic [OFFSET_BITS-1:0] first_hit_offset;

    t_scan_result match_reports [$];
    t_byte        region_buf [$];

    int mismatch_count  = 0;
    int bytes_offered   = 0;
    int bytes_taken     = 0;
    int regions_closed  = 0;
    int regions_found   = 0;
    int settings_used   = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int stuck_cycles    = 0;

    // Long receiver hold-off, requested by toggling hold_toggle
    logic hold_toggle = 1'b0;
    int   hold_len    = 0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic t_byte pattern_byte(input int i);
        return cfg_pattern[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic int active_length();
        int len;
        len = int'(cfg_length);
        if (len == 0) len = 1;
        if (len > MAX_PATTERN) len = MAX_PATTERN;
        return len;
    endfunction

    function automatic bit window_hit(input int len);
        for (int i = 0; i < len; i++) begin
            if (cfg_care[i] && scan_window[len - 1 - i] != pattern_byte(i)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_scanner();
        cfg_length = 6'd1;
        cfg_care   = '0;
        for (int w = 0; w < PAT_WORDS; w++) cfg_pattern[w] = '0;
        for (int k = 0; k < MAX_PATTERN; k++) scan_window[k] = '0;
        bytes_in_region  = '0;
        region_hit       = 1'b0;
        first_hit_offset = '0;
    endfunction

    // Shift one byte into the window, test the newest start, close the region on last
    function automatic void advance_window(input t_byte b, input logic last);
        int           len;
        t_scan_result res;
        len = active_length();
        for (int k = MAX_PATTERN - 1; k > 0; k--) scan_window[k] = scan_window[k - 1];
        scan_window[0] = b;
        if (bytes_in_region != '1) bytes_in_region++;
        if (!region_hit && bytes_in_region >= len && window_hit(len)) begin
            region_hit       = 1'b1;
            first_hit_offset = bytes_in_region - len;
        end
        if (last) begin
            res.found  = region_hit;
            res.offset = region_hit ? first_hit_offset[OUT_OFF_W-1:0] : '0;
            match_reports.push_back(res);
            regions_closed++;
            if (region_hit) regions_found++;
            bytes_in_region  = '0;
            region_hit       = 1'b0;
            first_hit_offset = '0;
        end
    endfunction

    // Track every accepted input word
    always @(posedge i_clk) begin
        if (i_rst_n && byte_if.valid && byte_if.ready) begin
            bytes_taken++;
            advance_window(byte_if.data_byte, byte_if.last_byte);
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        t_scan_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (match_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0b offset=%0d",
                                          res_if.found, res_if.match_offset));
            end else begin
                want = match_reports.pop_front();
                if (res_if.found !== want.found)
                    report_mismatch($sformatf("found %0b, want %0b", res_if.found, want.found));
                if (res_if.match_offset !== want.offset)
                    report_mismatch($sformatf("match_offset %0d, want %0d",
                                              res_if.match_offset, want.offset));
            end
        end
    end

    // Drive result ready: random idling or a requested long hold-off
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = hold_len;
        end
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // End the run when no word moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (byte_if.valid && byte_if.ready)
                || (res_if.valid && res_if.ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d reports pending",
                     stuck_cycles, match_reports.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Write one register; leave the enable high so writes can run back to back
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_LENGTH:   cfg_length     = data[CFG_LEN_W-1:0];
            REG_CARE:     cfg_care       = data[31:0];
            REG_PAT_LOW:  cfg_pattern[0] = data;
            REG_PAT_SEC:  cfg_pattern[1] = data;
            REG_PAT_THD:  cfg_pattern[2] = data;
            REG_PAT_HIGH: cfg_pattern[3] = data;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Offer one word, with a random gap first, and hold it until taken
    task automatic send_byte(input t_byte b, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.last_byte <= last;
        bytes_offered++;
        do @(posedge i_clk); while (!byte_if.ready);
    endtask

    task automatic send_region();
        for (int i = 0; i < region_buf.size(); i++)
            send_byte(region_buf[i], i == region_buf.size() - 1);
    endtask

    // Stop offering, let the last accepted word reach the scanner, then wait for
    // every pending report, plus a short settle
    task automatic drain_reports();
        byte_if.valid <= 1'b0;
        @(posedge i_clk);
        while (match_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Build a region of random bytes, optionally with copies of the pattern planted
    task automatic build_region(input int size, input int plants, input bit narrow);
        int len;
        int off;
        len = active_length();
        region_buf.delete();
        for (int i = 0; i < size; i++) begin
            if (narrow && $urandom_range(0, 1))
                region_buf.push_back(pattern_byte($urandom_range(0, len - 1)));
            else
                region_buf.push_back(t_byte'($urandom_range(0, 255)));
        end
        for (int p = 0; p < plants; p++) begin
            if (size >= len) begin
                off = $urandom_range(0, size - len);
                for (int i = 0; i < len; i++)
                    if (cfg_care[i]) region_buf[off + i] = pattern_byte(i);
            end
        end
    endtask

    task automatic test_reset_defaults();
        // Length 1 with no care bits: any byte matches at offset 0
        region_buf = '{8'h00};
        send_region();
        region_buf = '{8'hFF, 8'h00};
        send_region();
        drain_reports();
    endtask

    task automatic test_directed_cases();
        // Zero length acts as one
        write_reg(REG_LENGTH, 64'd0);
        write_reg(REG_CARE, 64'd1);
        write_reg(REG_PAT_LOW, 64'hFF);
        end_writes();
        region_buf = '{8'h00, 8'hFF, 8'h00};
        send_region();
        drain_reports();

        // Wildcard in the middle; byte past the length is cared for but ignored
        write_reg(REG_LENGTH, 64'd3);
        write_reg(REG_CARE, 64'hFFFF_FFFF_FFFF_FFFD);
        write_reg(REG_PAT_LOW, 64'h0000_0000_1155_99AA);
        end_writes();
        region_buf = '{8'h12, 8'hAA, 8'h7E, 8'h55};
        send_region();

        // Regions no longer than the pattern, with a stale window behind them
        region_buf = '{8'hAA};
        send_region();
        region_buf = '{8'h55};
        send_region();
        region_buf = '{8'hAA, 8'h00, 8'h55};
        send_region();
        drain_reports();

        // Oversized length acts as the maximum: three bytes cannot match
        write_reg(REG_LENGTH, 64'd63);
        write_reg(REG_CARE, 64'd0);
        write_reg(REG_PAT_SEC, {$urandom, $urandom});
        write_reg(REG_PAT_THD, {$urandom, $urandom});
        write_reg(REG_PAT_HIGH, {$urandom, $urandom});
        end_writes();
        region_buf = '{8'hFF, 8'h00, 8'hFF};
        send_region();
        drain_reports();
    endtask

    // Pick a setting; rotate through the length extremes
    task automatic random_setting(input int k);
        logic [31:0] care;
        int          len;
        case (k % 5)
            0: len = MAX_PATTERN;
            1: len = $urandom_range(0, 1);
            2: len = $urandom_range(MAX_PATTERN + 1, 63);
            default: len = $urandom_range(2, 10);
        endcase
        case ($urandom_range(0, 3))
            0: care = '1;
            1: care = '0;
            2: care = $urandom;
            default: care = $urandom & $urandom;
        endcase
        write_reg(REG_LENGTH, 64'(len));
        write_reg(REG_CARE, {$urandom, care});
        write_reg(REG_PAT_LOW, {$urandom, $urandom});
        write_reg(REG_PAT_SEC, {$urandom, $urandom});
        write_reg(REG_PAT_THD, {$urandom, $urandom});
        write_reg(REG_PAT_HIGH, {$urandom, $urandom});
        end_writes();
    endtask

    task automatic test_random_regions();
        int start;
        int len;
        int size;
        int r;
        int k;
        k = 0;
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 37; recv_idle_pct = 58; end
                1: begin send_idle_pct = 58; recv_idle_pct = 37; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            start = bytes_offered;
            while (bytes_offered - start < RANDOM_TARGET) begin
                random_setting(k);
                k++;
                len = active_length();
                repeat ($urandom_range(2, 5)) begin
                    r = $urandom_range(0, 99);
                    if (r < 12)      size = $urandom_range(1, len);
                    else if (r < 92) size = $urandom_range(len, len + 24);
                    else             size = $urandom_range(len, len + 120);
                    r = $urandom_range(0, 99);
                    build_region(size, (r < 30) ? 0 : (r < 85) ? 1 : 2,
                                 $urandom_range(0, 2) == 0);
                    send_region();
                end
                drain_reports();
            end
        end
    endtask

    task automatic test_result_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 20;
        random_setting(3);
        // Hold the result side off while short regions keep coming
        hold_len    <= 300;
        hold_toggle <= ~hold_toggle;
        repeat (16) begin
            build_region($urandom_range(1, 3), 1, 1'b0);
            send_region();
        end
        drain_reports();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= REG_LENGTH;
        cfg_data          <= '0;
        byte_if.valid     <= 1'b0;
        byte_if.data_byte <= '0;
        byte_if.last_byte <= 1'b0;
        clear_scanner();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_cases();
        test_random_regions();
        test_result_backpressure();

        drain_reports();
        $display("covered %0d bytes in %0d regions (%0d with a match) over %0d register settings",
                 bytes_taken, regions_closed, regions_found, settings_used);
        $display("mismatches: %0d, reports left over: %0d", mismatch_count, match_reports.size());
        if (mismatch_count == 0 && match_reports.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
